// ===== rtl/core/task_scheduler_select_macros.svh =====
// assertion macros shared by the checker of the task scheduler
`ifndef TASK_SCHEDULER_SELECT_MACROS_SVH
`define TASK_SCHEDULER_SELECT_MACROS_SVH

// same-cycle implication, reset masks the check
`define TSS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define TSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tss_pkg.sv =====
package tss_pkg;

  // default table size
  localparam int DEF_TASK_SLOTS = 16;

  // fixed field widths
  localparam int SLOT_IDX_W = 4;
  localparam int PRIO_W     = 8;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd1;

  // register reset values
  localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd0;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  // request commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  // scheduling modes, the unused code acts as round robin
  typedef enum logic [MODE_W-1:0] {
    MODE_RR   = 2'd0,
    MODE_PRIO = 2'd1,
    MODE_PRR  = 2'd2
  } mode_e;

  // one task slot as stored in the table
  typedef struct packed {
    logic              ready;
    logic              idle;
    logic [PRIO_W-1:0] prio;
  } tss_entry_t;

  localparam int ENTRY_W = $bits(tss_entry_t);

endpackage

// ===== rtl/core/tss_if.sv =====
// request channel into the scheduler
interface tss_in_if import tss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic                  slot_ready;
  logic [PRIO_W-1:0]     slot_priority;
  logic                  slot_is_idle;

  modport source (
    output valid, command, slot_index, slot_ready, slot_priority, slot_is_idle,
    input  ready
  );
  modport sink (
    input  valid, command, slot_index, slot_ready, slot_priority, slot_is_idle,
    output ready
  );
endinterface

// result channel out of the scheduler
interface tss_out_if import tss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SLOT_IDX_W-1:0] next_slot;

  modport source (
    output valid, next_slot,
    input  ready
  );
  modport sink (
    input  valid, next_slot,
    output ready
  );
endinterface

// ===== rtl/core/task_scheduler_select.sv =====
// Task scheduler over a table of TASK_SLOTS slots (ready flag, 8-bit priority,
// idle mark). A write request updates one slot and gives no result; writes to
// slots outside the table are dropped. A schedule request picks the next
// running slot in round robin, strict priority or priority round robin mode
// and returns it. The table sits in a RAM with one write port and a
// registered read port, scanned one slot per cycle, and one 8-bit comparator
// does all priority tests. The input is not ready while a decision runs.
// Per-slot valid flip-flops make the table read as zero after reset, so no
// clearing pass is needed.
module task_scheduler_select import tss_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tss_in_if.sink                in_i,
  tss_out_if.source             out_o
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int NW = $clog2(TASK_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    PASS_RR,
    PASS_P1,
    PASS_P2,
    PASS_R1,
    PASS_R2
  } pass_e;

  state_e                state_q, state_d;
  pass_e                 pass_q, pass_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [TASK_SLOTS-1:0] valid_q, valid_d;
  logic [SW-1:0]         iss_addr_q, iss_addr_d;
  logic [NW-1:0]         iss_left_q, iss_left_d;
  logic                  rd_vld_q, rd_vld_d;
  logic                  rd_last_q, rd_last_d;
  logic [SW-1:0]         rd_idx_q, rd_idx_d;
  logic                  vbit_q, vbit_d;
  logic [PRIO_W-1:0]     best_q, best_d;
  logic                  seen_q, seen_d;
  logic [SW-1:0]         cand_q, cand_d;
  logic [SW-1:0]         running_q, running_d;
  logic                  out_valid_q, out_valid_d;
  logic [SLOT_IDX_W-1:0] out_slot_q, out_slot_d;

  logic [NW-1:0]         n_used;
  logic [SW-1:0]         scan_start;
  logic [SW-1:0]         rr_start;
  logic [SW-1:0]         iss_next;
  logic                  in_acc;
  logic                  wr_ok;
  logic [SW-1:0]         waddr;
  tss_entry_t            wentry;
  tss_entry_t            rentry;
  logic [ENTRY_W-1:0]    rdata;
  logic                  ram_we;
  logic                  rdy;
  logic                  idl;
  logic                  prio_gt;
  logic                  prio_eq;
  logic                  go_finish;
  logic                  go_next;
  logic [SW-1:0]         fin_slot;
  logic [31:0]           cand_ext;

  // next slot index, wrapping at the slot count
  function automatic logic [SW-1:0] wrap_inc(logic [SW-1:0] a, logic [NW-1:0] n);
    logic [NW-1:0] nxt;
    nxt = NW'(a) + NW'(1);
    return (nxt >= n) ? '0 : SW'(nxt);
  endfunction

  // effective slot count
  always_comb begin
    if (count_q == '0) begin
      n_used = NW'(1);
    end else if (32'(count_q) > TASK_SLOTS) begin
      n_used = NW'(TASK_SLOTS);
    end else begin
      n_used = NW'(count_q);
    end
  end

  // scan start points
  assign scan_start = (NW'(running_q) >= n_used) ? '0 : running_q;
  assign rr_start   = wrap_inc(running_q, n_used);
  assign iss_next   = wrap_inc(iss_addr_q, n_used);

  // request side
  assign in_acc = in_i.valid && in_i.ready;
  assign wr_ok  = 32'(in_i.slot_index) < TASK_SLOTS;
  assign waddr  = SW'(in_i.slot_index);
  assign wentry = '{ready: in_i.slot_ready, idle: in_i.slot_is_idle,
                    prio: in_i.slot_priority};

  // task table
  tss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASK_SLOTS)
  ) u_tss_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (iss_addr_q),
    .rdata_o (rdata)
  );

  // slot under evaluation, never-written slots read as zero
  assign rentry  = rdata;
  assign rdy     = vbit_q && rentry.ready;
  assign idl     = vbit_q && rentry.idle;

  // shared priority comparator
  assign prio_gt = rentry.prio > best_q;
  assign prio_eq = rentry.prio == best_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    mode_d      = mode_q;
    count_d     = count_q;
    valid_d     = valid_q;
    iss_addr_d  = iss_addr_q;
    iss_left_d  = iss_left_q;
    rd_vld_d    = 1'b0;
    rd_last_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    vbit_d      = vbit_q;
    best_d      = best_q;
    seen_d      = seen_q;
    cand_d      = cand_q;
    running_d   = running_q;
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    ram_we      = 1'b0;
    go_finish   = 1'b0;
    go_next     = 1'b0;
    fin_slot    = '0;
    cand_ext    = 32'(cand_q);

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCHED_MODE: mode_d  = cfg_data_i[MODE_W-1:0];
        CFG_TASK_COUNT: count_d = cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end

    // result taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.command == CMD_SCHED) begin
            state_d    = ST_SCAN;
            iss_left_d = n_used;
            seen_d     = 1'b0;
            case (mode_q)
              MODE_PRIO: begin
                pass_d     = PASS_P1;
                iss_addr_d = scan_start;
              end
              MODE_PRR: begin
                pass_d     = PASS_R1;
                iss_addr_d = '0;
              end
              default: begin
                pass_d     = PASS_RR;
                iss_addr_d = rr_start;
              end
            endcase
          end else if (wr_ok) begin
            ram_we         = 1'b1;
            valid_d[waddr] = 1'b1;
          end
        end
      end

      ST_SCAN: begin
        // evaluate the slot read last cycle
        if (rd_vld_q) begin
          case (pass_q)
            PASS_RR: begin
              if (rdy && !idl) begin
                go_finish = 1'b1;
                fin_slot  = rd_idx_q;
              end else if (rd_last_q) begin
                go_finish = 1'b1;
              end
            end
            PASS_P1: begin
              if (rdy) begin
                best_d = rentry.prio;
                cand_d = rd_idx_q;
                if (n_used == NW'(1)) begin
                  go_finish = 1'b1;
                  fin_slot  = rd_idx_q;
                end else begin
                  go_next = 1'b1;
                end
              end else if (rd_last_q) begin
                go_finish = 1'b1;
              end
            end
            PASS_P2: begin
              fin_slot = cand_q;
              if (rdy && prio_gt) begin
                best_d   = rentry.prio;
                cand_d   = rd_idx_q;
                fin_slot = rd_idx_q;
              end
              go_finish = rd_last_q;
            end
            PASS_R1: begin
              if (rdy && (!seen_q || prio_gt)) begin
                best_d = rentry.prio;
                seen_d = 1'b1;
              end
              if (rd_last_q) begin
                if (seen_d) begin
                  go_next = 1'b1;
                end else begin
                  go_finish = 1'b1;
                end
              end
            end
            PASS_R2: begin
              if (rdy && prio_eq) begin
                go_finish = 1'b1;
                fin_slot  = rd_idx_q;
              end else if (rd_last_q) begin
                go_finish = 1'b1;
              end
            end
            default: go_finish = 1'b1;
          endcase
        end

        if (go_finish) begin
          state_d = ST_FINISH;
          cand_d  = fin_slot;
        end else if (go_next) begin
          // second pass of a priority mode
          if (pass_q == PASS_P1) begin
            pass_d     = PASS_P2;
            iss_addr_d = SW'(1);
            iss_left_d = n_used - NW'(1);
          end else begin
            pass_d     = PASS_R2;
            iss_addr_d = scan_start;
            iss_left_d = n_used;
          end
        end else if (iss_left_q != '0) begin
          // read the next slot
          rd_vld_d   = 1'b1;
          rd_last_d  = (iss_left_q == NW'(1));
          rd_idx_d   = iss_addr_q;
          vbit_d     = valid_q[iss_addr_q];
          iss_addr_d = iss_next;
          iss_left_d = iss_left_q - NW'(1);
        end
      end

      ST_FINISH: begin
        // hand the pick to the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_slot_d  = cand_ext[SLOT_IDX_W-1:0];
          running_d   = cand_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_RR;
      mode_q      <= MODE_RESET;
      count_q     <= COUNT_RESET;
      valid_q     <= '0;
      iss_addr_q  <= '0;
      iss_left_q  <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_idx_q    <= '0;
      vbit_q      <= 1'b0;
      best_q      <= '0;
      seen_q      <= 1'b0;
      cand_q      <= '0;
      running_q   <= '0;
      out_valid_q <= 1'b0;
      out_slot_q  <= '0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      iss_addr_q  <= iss_addr_d;
      iss_left_q  <= iss_left_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      rd_idx_q    <= rd_idx_d;
      vbit_q      <= vbit_d;
      best_q      <= best_d;
      seen_q      <= seen_d;
      cand_q      <= cand_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
      out_slot_q  <= out_slot_d;
    end
  end

  // handshake outputs
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.next_slot = out_slot_q;

endmodule

// ===== rtl/core/tss_ram.sv =====
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/tss_checker.sv =====
`include "task_scheduler_select_macros.svh"

module tss_checker import tss_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_command_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [SLOT_IDX_W-1:0] out_slot_i
);

  logic sched_acc;
  logic out_stall;

  assign sched_acc = in_valid_i && in_ready_i && (in_command_i == CMD_SCHED);
  assign out_stall = out_valid_i && !out_ready_i;

  // a stalled result holds its value
  `TSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_slot_i), "stalled result changed")

  // a schedule request blocks the input while it runs
  `TSS_ASSERT_NEXT(a_sched_busy, clk_i, rst_ni, sched_acc, !in_ready_i, "input ready during a decision")

  // a new result only comes out of a running decision
  `TSS_ASSERT_IMPLY(a_out_source, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i), "result without a decision")

  // the chosen slot lies inside the table
  `TSS_ASSERT_IMPLY(a_slot_range, clk_i, rst_ni, out_valid_i, 32'(out_slot_i) < TASK_SLOTS, "slot beyond table")

endmodule

bind task_scheduler_select tss_checker #(
  .TASK_SLOTS (TASK_SLOTS)
) u_tss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_slot_i   (out_o.next_slot)
);

// ===== sim/tss_sched_check_pkg.sv =====
package tss_sched_check_pkg;
  import tss_pkg::*;

  // one request as driven on the input channel
  typedef struct packed {
    logic                  command;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  slot_ready;
    logic [PRIO_W-1:0]     slot_priority;
    logic                  slot_is_idle;
  } sched_req_t;

  class sched_scoreboard;
    tss_entry_t            slot_table [DEF_TASK_SLOTS];
    logic [SLOT_IDX_W-1:0] running_slot;
    logic [MODE_W-1:0]     mode_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [SLOT_IDX_W-1:0] expected_slots [$];
    int unsigned           mismatches;
    int unsigned           slot_writes;
    int unsigned           decisions_by_mode [4];

    function new();
      foreach (slot_table[i]) slot_table[i] = '0;
      running_slot = '0;
      mode_reg     = MODE_RESET;
      count_reg    = COUNT_RESET;
      mismatches   = 0;
      slot_writes  = 0;
      foreach (decisions_by_mode[i]) decisions_by_mode[i] = 0;
    endfunction

    // register writes, unknown indexes are dropped
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCHED_MODE: mode_reg = data[MODE_W-1:0];
        CFG_TASK_COUNT: count_reg = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // zero counts as one, oversize clamps to the table
    function int unsigned slots_in_use();
      if (count_reg == 0) return 1;
      if (count_reg > DEF_TASK_SLOTS) return DEF_TASK_SLOTS;
      return count_reg;
    endfunction

    // next ready non-idle slot after the running one
    function logic [SLOT_IDX_W-1:0] pick_round_robin(int unsigned n);
      int unsigned p;
      bit          found;
      p     = running_slot;
      found = 1'b0;
      for (int unsigned k = 0; k < n; k++) begin
        if (!found) begin
          p++;
          if (p >= n) p = 0;
          if (slot_table[p].ready && !slot_table[p].idle) found = 1'b1;
        end
      end
      return found ? SLOT_IDX_W'(p) : '0;
    endfunction

    // first ready slot from the running one, beaten only by strictly higher priority
    function logic [SLOT_IDX_W-1:0] pick_priority(int unsigned n);
      int unsigned       p;
      bit                found;
      logic [PRIO_W-1:0] best;
      p     = running_slot;
      found = 1'b0;
      if (p >= n) p = 0;
      for (int unsigned k = 0; k < n; k++) begin
        if (!found) begin
          if (slot_table[p].ready) found = 1'b1;
          else begin
            p++;
            if (p >= n) p = 0;
          end
        end
      end
      if (!found) return '0;
      best = slot_table[p].prio;
      for (int unsigned k = 1; k < n; k++) begin
        if (slot_table[k].ready && slot_table[k].prio > best) begin
          p    = k;
          best = slot_table[k].prio;
        end
      end
      return SLOT_IDX_W'(p);
    endfunction

    // first slot of the top ready priority, scanning from the running one
    function logic [SLOT_IDX_W-1:0] pick_priority_rr(int unsigned n);
      logic [PRIO_W-1:0] top;
      bit                seen;
      bit                found;
      int unsigned       start;
      int unsigned       idx;
      int unsigned       pick;
      top   = '0;
      seen  = 1'b0;
      found = 1'b0;
      pick  = 0;
      for (int unsigned k = 0; k < n; k++) begin
        if (slot_table[k].ready && (!seen || slot_table[k].prio > top)) begin
          top  = slot_table[k].prio;
          seen = 1'b1;
        end
      end
      if (!seen) return '0;
      start = running_slot;
      if (start >= n) start = 0;
      for (int unsigned k = 0; k < n; k++) begin
        idx = start + k;
        if (idx >= n) idx -= n;
        if (!found && slot_table[idx].ready && slot_table[idx].prio == top) begin
          pick  = idx;
          found = 1'b1;
        end
      end
      return SLOT_IDX_W'(pick);
    endfunction

    // update the table or predict the decision for an accepted request
    function void note_request(sched_req_t r);
      logic [SLOT_IDX_W-1:0] pick;
      int unsigned           n;
      if (r.command == CMD_WRITE) begin
        if (int'(r.slot_index) < DEF_TASK_SLOTS) begin
          slot_table[r.slot_index].ready = r.slot_ready;
          slot_table[r.slot_index].idle  = r.slot_is_idle;
          slot_table[r.slot_index].prio  = r.slot_priority;
        end
        slot_writes++;
        return;
      end
      n = slots_in_use();
      case (mode_e'(mode_reg))
        MODE_PRIO: pick = pick_priority(n);
        MODE_PRR:  pick = pick_priority_rr(n);
        default:   pick = pick_round_robin(n);
      endcase
      running_slot = pick;
      expected_slots.push_back(pick);
      decisions_by_mode[mode_reg]++;
    endfunction

    function int unsigned pending();
      return expected_slots.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // compare one returned slot against the oldest prediction
    task check_result(logic [SLOT_IDX_W-1:0] got);
      logic [SLOT_IDX_W-1:0] want;
      if (expected_slots.size() == 0) begin
        report($sformatf("next_slot %0d returned with no decision outstanding", got));
      end else begin
        want = expected_slots.pop_front();
        if (got !== want)
          report($sformatf("next_slot %0d, predicted %0d", got, want));
      end
    endtask
  endclass

endpackage

// ===== sim/tb_task_scheduler_select.sv =====
module tb_task_scheduler_select;
  timeunit 1ns;
  timeprecision 1ps;
  import tss_pkg::*;
  import tss_sched_check_pkg::*;

  // register index and mode codes the block must ignore or fold
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_SPARE     = 2'd3;

  localparam int SETTLE_CYCLES  = 48;
  localparam int PHASES         = 14;
  localparam int PHASE_REQUESTS = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tss_in_if  req_ch ();
  tss_out_if res_ch ();

  task_scheduler_select #(.TASK_SLOTS(DEF_TASK_SLOTS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_ch.sink),
    .out_o      (res_ch.source)
  );

  sched_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned settings_seen;

  logic [MODE_W-1:0] mode_plan  [4]      = '{MODE_RR, MODE_PRIO, MODE_PRR, MODE_SPARE};
  int unsigned       count_plan [PHASES] = '{16, 1, 2, 0, 31, 17, 16, 5, 3, 12, 8, 16, 4, 9};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: check on handshake, stall at random
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) sb.check_result(res_ch.next_slot);
      res_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // drive one request and wait for it to be taken
  task automatic drive_request(input sched_req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.command       <= r.command;
    req_ch.slot_index    <= r.slot_index;
    req_ch.slot_ready    <= r.slot_ready;
    req_ch.slot_priority <= r.slot_priority;
    req_ch.slot_is_idle  <= r.slot_is_idle;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic write_slot(input int idx, input bit rdy, input int prio, input bit idle);
    sched_req_t r;
    r.command       = CMD_WRITE;
    r.slot_index    = SLOT_IDX_W'(idx);
    r.slot_ready    = rdy;
    r.slot_priority = PRIO_W'(prio);
    r.slot_is_idle  = idle;
    drive_request(r);
  endtask

  task automatic request_decision();
    sched_req_t r;
    r         = sched_req_t'($urandom);
    r.command = CMD_SCHED;
    drive_request(r);
  endtask

  // hold off until every decision is back and the block has gone quiet
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
    settings_seen++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned sel);
    case (sel)
      1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      3: begin send_idle_pct = 33; recv_stall_pct = 33; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // random request, slots mostly inside the active range, priorities often tied
  function automatic sched_req_t random_request();
    sched_req_t  r;
    int unsigned n;
    n       = sb.slots_in_use();
    r       = sched_req_t'($urandom);
    r.command = ($urandom_range(99) < 40) ? CMD_SCHED : CMD_WRITE;
    if ($urandom_range(99) < 70) r.slot_index = SLOT_IDX_W'($urandom_range(n - 1));
    r.slot_ready   = ($urandom_range(99) < 55);
    r.slot_is_idle = ($urandom_range(99) < 25);
    case ($urandom_range(9))
      0:          r.slot_priority = '0;
      1:          r.slot_priority = '1;
      2, 3, 4, 5: r.slot_priority = PRIO_W'($urandom_range(3));
      default:    r.slot_priority = PRIO_W'($urandom);
    endcase
    return r;
  endfunction

  // directed: empty table, extremes, every mode, count folding, spare codes
  task automatic run_directed();
    request_decision();
    write_slot(15, 1'b1, 255, 1'b0);
    write_slot(0, 1'b1, 0, 1'b1);
    write_slot(5, 1'b1, 255, 1'b1);
    write_slot(7, 1'b1, 128, 1'b0);
    repeat (3) request_decision();
    quiesce();
    cfg_write(CFG_SCHED_MODE, {3'b111, MODE_PRIO});
    repeat (2) request_decision();
    quiesce();
    cfg_write(CFG_SCHED_MODE, {3'b000, MODE_PRR});
    repeat (2) request_decision();
    // running slot now above the shrunk count
    quiesce();
    cfg_write(CFG_TASK_COUNT, 5'd4);
    request_decision();
    quiesce();
    cfg_write(CFG_SCHED_MODE, {3'b010, MODE_PRIO});
    request_decision();
    quiesce();
    cfg_write(CFG_TASK_COUNT, 5'd0);
    request_decision();
    quiesce();
    cfg_write(CFG_TASK_COUNT, 5'd31);
    cfg_write(CFG_SCHED_MODE, {3'b101, MODE_SPARE});
    cfg_write(CFG_IDX_SPARE0, 5'b11111);
    cfg_write(CFG_IDX_SPARE1, 5'b10101);
    request_decision();
    write_slot(15, 1'b0, 0, 1'b1);
    request_decision();
    quiesce();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    req_ch.valid         = 1'b0;
    req_ch.command       = CMD_WRITE;
    req_ch.slot_index    = '0;
    req_ch.slot_ready    = 1'b0;
    req_ch.slot_priority = '0;
    req_ch.slot_is_idle  = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    settings_seen        = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // random phases, each with its own setting and idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      cfg_write(CFG_TASK_COUNT, CFG_DATA_W'(count_plan[ph]));
      cfg_write(CFG_SCHED_MODE, {3'($urandom), mode_plan[ph % 4]});
      if (ph % 3 == 0) cfg_write(($urandom_range(1) != 0) ? CFG_IDX_SPARE1 : CFG_IDX_SPARE0,
                                 CFG_DATA_W'($urandom));
      set_idling(ph % 4);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        // sender holds off until the decisions in flight have drained
        if (ph == 6 && i == PHASE_REQUESTS / 2) begin
          req_ch.valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk_i);
        end
        drive_request(random_request());
      end
    end
    quiesce();

    $display("run covered %0d slot writes and %0d decisions over %0d register writes",
             sb.slot_writes,
             sb.decisions_by_mode[0] + sb.decisions_by_mode[1] +
             sb.decisions_by_mode[2] + sb.decisions_by_mode[3], settings_seen);
    $display("decisions per mode code 0..3: %0d %0d %0d %0d, mismatches %0d",
             sb.decisions_by_mode[0], sb.decisions_by_mode[1],
             sb.decisions_by_mode[2], sb.decisions_by_mode[3], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
